FILE: design/assert_macros.svh
// Assertion helpers for the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the cycle after ante.
`define GCL_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gradient lookup assertion failed");

// Check cons in the same cycle as ante.
`define GCL_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gradient lookup assertion failed");

`endif

FILE: design/gcl_pkg.sv
package gcl_pkg;

	localparam int MAX_STOPS     = 256;
	localparam int FRACTION_BITS = 16;

	localparam int ADDR_W  = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam int SIDX_W  = ADDR_W + 2;
	localparam int POS_W   = FRACTION_BITS + 1;
	localparam int KEY_W   = 20;
	localparam int SLOT_W  = 8;
	localparam int COUNT_W = 9;
	localparam int CH_W    = 8;
	localparam int CH_N    = 4;
	localparam int COLOR_W = CH_W * CH_N;
	localparam int ENTRY_W = POS_W + COLOR_W;
	localparam int NUM_W   = CH_W + POS_W;
	localparam int STEP_W  = $clog2(CH_W);
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	localparam logic [POS_W-1:0]   POS_ONE     = POS_W'(1) << FRACTION_BITS;
	localparam logic [COLOR_W-1:0] RESET_COLOR = COLOR_W'(1) << (3 * CH_W);
	localparam logic [ENTRY_W-1:0] RESET_ENTRY = {POS_W'(0), RESET_COLOR};

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FETCH_I,
		ST_FETCH_J,
		ST_BLEND,
		ST_OUT
	} gcl_state_t;

	typedef enum logic [1:0] {
		BL_IDLE,
		BL_MUL,
		BL_DIV
	} blend_phase_t;

	typedef struct packed {
		logic               en;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] data;
	} store_wr_t;

	typedef struct packed {
		logic               start;
		logic [POS_W-1:0]   seg_len;
		logic [POS_W-1:0]   off;
		logic [COLOR_W-1:0] ci;
		logic [COLOR_W-1:0] cj;
	} blend_req_t;

	typedef struct packed {
		logic               done;
		logic [COLOR_W-1:0] color;
	} blend_rsp_t;

endpackage

FILE: design/gcl_ram.sv
module gcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/gcl_store.sv
module gcl_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gcl_pkg::store_wr_t             wr,
	input  logic [gcl_pkg::ADDR_W-1:0]     raddr,
	output logic [gcl_pkg::ENTRY_W-1:0]    rdata
);

	logic [gcl_pkg::MAX_STOPS-1:0] valid_q;
	logic                          rvalid_q;
	logic [gcl_pkg::ENTRY_W-1:0]   ram_rdata;

	gcl_ram #(
		.WIDTH(gcl_pkg::ENTRY_W),
		.DEPTH(gcl_pkg::MAX_STOPS)
	) u_ram (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.data),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			rvalid_q <= valid_q[raddr];
		end
	end

	assign rdata = rvalid_q ? ram_rdata : gcl_pkg::RESET_ENTRY;

endmodule

FILE: design/gcl_blend.sv
module gcl_blend (
	input  logic                clk,
	input  logic                arst_n,
	input  gcl_pkg::blend_req_t req,
	output gcl_pkg::blend_rsp_t rsp
);

	localparam logic [gcl_pkg::STEP_W-1:0] LAST_STEP = gcl_pkg::STEP_W'(gcl_pkg::CH_W - 1);

	gcl_pkg::blend_phase_t phase_q, phase_d;
	logic [gcl_pkg::STEP_W-1:0] step_q;
	logic                       done_q;

	logic [gcl_pkg::NUM_W-1:0] acc_q [gcl_pkg::CH_N];
	logic [gcl_pkg::CH_W-1:0]  a_q   [gcl_pkg::CH_N];
	logic [gcl_pkg::CH_W-1:0]  b_q   [gcl_pkg::CH_N];
	logic [gcl_pkg::POS_W-1:0] span_q;
	logic [gcl_pkg::POS_W-1:0] off_q;
	logic [gcl_pkg::NUM_W-1:0] dsh_q;

	logic [gcl_pkg::NUM_W-1:0] mul_next [gcl_pkg::CH_N];
	logic [gcl_pkg::NUM_W-1:0] div_rem  [gcl_pkg::CH_N];
	logic                      ge       [gcl_pkg::CH_N];

	always_comb begin
		for (int l = 0; l < gcl_pkg::CH_N; l++) begin
			mul_next[l] = (acc_q[l] << 1)
				+ (a_q[l][gcl_pkg::CH_W-1] ? gcl_pkg::NUM_W'(span_q) : '0)
				+ (b_q[l][gcl_pkg::CH_W-1] ? gcl_pkg::NUM_W'(off_q) : '0);
			ge[l]      = acc_q[l] >= dsh_q;
			div_rem[l] = acc_q[l] - dsh_q;
		end
	end

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			gcl_pkg::BL_IDLE: begin
				if (req.start) begin
					phase_d = gcl_pkg::BL_MUL;
				end
			end
			gcl_pkg::BL_MUL: begin
				if (step_q == LAST_STEP) begin
					phase_d = gcl_pkg::BL_DIV;
				end
			end
			gcl_pkg::BL_DIV: begin
				if (step_q == LAST_STEP) begin
					phase_d = gcl_pkg::BL_IDLE;
				end
			end
			default: phase_d = gcl_pkg::BL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gcl_pkg::BL_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == gcl_pkg::BL_DIV) && (step_q == LAST_STEP);
			if (phase_q == gcl_pkg::BL_IDLE) begin
				step_q <= '0;
			end else begin
				step_q <= (step_q == LAST_STEP) ? '0 : step_q + gcl_pkg::STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			gcl_pkg::BL_IDLE: begin
				if (req.start) begin
					for (int l = 0; l < gcl_pkg::CH_N; l++) begin
						acc_q[l] <= '0;
						a_q[l]   <= req.ci[l*gcl_pkg::CH_W +: gcl_pkg::CH_W];
						b_q[l]   <= req.cj[l*gcl_pkg::CH_W +: gcl_pkg::CH_W];
					end
					span_q <= req.seg_len - req.off;
					off_q  <= req.off;
					dsh_q  <= gcl_pkg::NUM_W'(req.seg_len) << (gcl_pkg::CH_W - 1);
				end
			end
			gcl_pkg::BL_MUL: begin
				for (int l = 0; l < gcl_pkg::CH_N; l++) begin
					acc_q[l] <= mul_next[l];
					a_q[l]   <= a_q[l] << 1;
					b_q[l]   <= b_q[l] << 1;
				end
			end
			gcl_pkg::BL_DIV: begin
				for (int l = 0; l < gcl_pkg::CH_N; l++) begin
					if (ge[l]) begin
						acc_q[l] <= div_rem[l];
					end
					a_q[l] <= {a_q[l][gcl_pkg::CH_W-2:0], ge[l]};
				end
				dsh_q <= dsh_q >> 1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rsp.done = done_q;
		for (int l = 0; l < gcl_pkg::CH_N; l++) begin
			rsp.color[l*gcl_pkg::CH_W +: gcl_pkg::CH_W] = a_q[l];
		end
	end

endmodule

FILE: design/gradient_colormap_lookup_core.sv
// Channel   Handshake                 Carries
// in        in_valid / in_stall       cmd, slot, stop_position, color, key
// out       out_valid / out_stall     red_out, green_out, blue_out, alpha_out
// config    psel / penable / pready   color_count at any address (paddr unused)
//
// A write request is accepted without raising in_stall and produces no result.
// A lookup request makes one stop-table read per binary-search probe (up to 9
// at 256 stops), reads the bracketing stops and, if needed, runs one shift-add
// and one restoring-divide step per channel bit in the four-lane blend unit.
// in_stall is high while a lookup is in flight; a held result in the output
// register does not block new requests. Reset clears all stops to position 0,
// black with alpha 1, through per-entry valid bits.
module gradient_colormap_lookup_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [gcl_pkg::SLOT_W-1:0]    slot,
	input  logic [gcl_pkg::POS_W-1:0]     stop_position,
	input  logic [gcl_pkg::CH_W-1:0]      red_in,
	input  logic [gcl_pkg::CH_W-1:0]      green_in,
	input  logic [gcl_pkg::CH_W-1:0]      blue_in,
	input  logic [gcl_pkg::CH_W-1:0]      alpha_in,
	input  logic [gcl_pkg::KEY_W-1:0]     key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gcl_pkg::CH_W-1:0]      red_out,
	output logic [gcl_pkg::CH_W-1:0]      green_out,
	output logic [gcl_pkg::CH_W-1:0]      blue_out,
	output logic [gcl_pkg::CH_W-1:0]      alpha_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gcl_pkg::PADDR_W-1:0]   paddr,
	input  logic [gcl_pkg::PDATA_W-1:0]   pwdata,
	output logic [gcl_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int AW = gcl_pkg::ADDR_W;
	localparam int SW = gcl_pkg::SIDX_W;
	localparam int PW = gcl_pkg::POS_W;
	localparam int CW = gcl_pkg::COLOR_W;

	gcl_pkg::gcl_state_t state_q, state_d;

	logic [gcl_pkg::COUNT_W-1:0] color_count_q;
	logic [PW-1:0]               key_q;
	logic signed [SW-1:0]        lo_q, hi_q;
	logic [AW-1:0]               mid_q, sel_q;
	logic [PW-1:0]               pos_i_q;
	logic [CW-1:0]               col_i_q, res_q, out_color_q;
	logic                        out_valid_q;

	logic                 accept_in, lookup_go, out_free;
	logic [PW-1:0]        key_red;
	logic [SW-1:0]        n_act, n_last;
	logic [AW-1:0]        mid0;
	logic [AW-1:0]        raddr;
	logic [gcl_pkg::ENTRY_W-1:0] entry;
	logic [PW-1:0]        e_pos;
	logic [CW-1:0]        e_col;

	logic signed [SW-1:0] mid_s, lo_n, hi_n, lo_m1, sum_n;
	logic                 p_lt, p_eq, search_more;
	logic [AW-1:0]        mid_n, found_idx;
	logic                 last_i, early, flat;
	logic [PW-1:0]        seg_len, off_raw, off;

	gcl_pkg::store_wr_t  wr;
	gcl_pkg::blend_req_t breq;
	gcl_pkg::blend_rsp_t brsp;

	// Configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_count_q <= gcl_pkg::COUNT_W'(1);
		end else if (psel && penable && pwrite) begin
			color_count_q <= pwdata[gcl_pkg::COUNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = gcl_pkg::PDATA_W'(color_count_q);

	assign in_stall  = (state_q != gcl_pkg::ST_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign lookup_go = accept_in && (cmd == gcl_pkg::CMD_LOOKUP);
	assign out_free  = !out_valid_q || !out_stall;

	assign key_red = (key == gcl_pkg::KEY_W'(gcl_pkg::POS_ONE)) ? gcl_pkg::POS_ONE
		: PW'(key[gcl_pkg::FRACTION_BITS-1:0]);

	always_comb begin
		if (color_count_q == '0) begin
			n_act = SW'(1);
		end else if (32'(color_count_q) > 32'(gcl_pkg::MAX_STOPS)) begin
			n_act = SW'(gcl_pkg::MAX_STOPS);
		end else begin
			n_act = SW'(color_count_q);
		end
		n_last = n_act - SW'(1);
		mid0   = n_last[AW:1];
	end

	assign wr.en   = accept_in && (cmd == gcl_pkg::CMD_WRITE)
		&& (32'(slot) < 32'(gcl_pkg::MAX_STOPS));
	assign wr.addr = AW'(slot);
	assign wr.data = {stop_position, alpha_in, blue_in, green_in, red_in};

	gcl_store u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (wr),
		.raddr (raddr),
		.rdata (entry)
	);

	assign e_pos = entry[gcl_pkg::ENTRY_W-1 -: PW];
	assign e_col = entry[CW-1:0];

	// Binary-search step on the probe that just came back
	always_comb begin
		mid_s       = $signed({2'b00, mid_q});
		p_lt        = e_pos < key_q;
		p_eq        = e_pos == key_q;
		lo_n        = p_lt ? mid_s + SW'(1) : lo_q;
		hi_n        = p_lt ? hi_q : mid_s - SW'(1);
		search_more = !p_eq && (lo_n <= hi_n);
		sum_n       = lo_n + hi_n;
		mid_n       = sum_n[AW:1];
		lo_m1       = lo_n - SW'(1);
		if (p_eq) begin
			found_idx = mid_q;
		end else if (lo_m1[SW-1]) begin
			found_idx = '0;
		end else begin
			found_idx = lo_m1[AW-1:0];
		end
	end

	assign last_i  = ({2'b00, sel_q} == n_last);
	assign early   = (key_q <= e_pos) || last_i;
	assign flat    = e_pos <= pos_i_q;
	assign seg_len = e_pos - pos_i_q;
	assign off_raw = key_q - pos_i_q;
	assign off     = (off_raw > seg_len) ? seg_len : off_raw;

	assign breq.start   = (state_q == gcl_pkg::ST_FETCH_J) && !flat;
	assign breq.seg_len = seg_len;
	assign breq.off     = off;
	assign breq.ci      = col_i_q;
	assign breq.cj      = e_col;

	gcl_blend u_blend (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (breq),
		.rsp   (brsp)
	);

	always_comb begin
		state_d = state_q;
		raddr   = mid0;
		case (state_q)
			gcl_pkg::ST_IDLE: begin
				if (lookup_go) begin
					state_d = gcl_pkg::ST_SEARCH;
				end
			end
			gcl_pkg::ST_SEARCH: begin
				if (search_more) begin
					raddr = mid_n;
				end else begin
					raddr   = found_idx;
					state_d = gcl_pkg::ST_FETCH_I;
				end
			end
			gcl_pkg::ST_FETCH_I: begin
				raddr   = sel_q + AW'(1);
				state_d = early ? gcl_pkg::ST_OUT : gcl_pkg::ST_FETCH_J;
			end
			gcl_pkg::ST_FETCH_J: begin
				state_d = flat ? gcl_pkg::ST_OUT : gcl_pkg::ST_BLEND;
			end
			gcl_pkg::ST_BLEND: begin
				if (brsp.done) begin
					state_d = gcl_pkg::ST_OUT;
				end
			end
			gcl_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = gcl_pkg::ST_IDLE;
				end
			end
			default: state_d = gcl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gcl_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == gcl_pkg::ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gcl_pkg::ST_IDLE: begin
				if (lookup_go) begin
					key_q <= key_red;
					lo_q  <= '0;
					hi_q  <= $signed(n_last);
					mid_q <= mid0;
				end
			end
			gcl_pkg::ST_SEARCH: begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
				sel_q <= found_idx;
			end
			gcl_pkg::ST_FETCH_I: begin
				pos_i_q <= e_pos;
				col_i_q <= e_col;
				res_q   <= e_col;
			end
			gcl_pkg::ST_BLEND: begin
				if (brsp.done) begin
					res_q <= brsp.color;
				end
			end
			gcl_pkg::ST_OUT: begin
				if (out_free) begin
					out_color_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign red_out   = out_color_q[0*gcl_pkg::CH_W +: gcl_pkg::CH_W];
	assign green_out = out_color_q[1*gcl_pkg::CH_W +: gcl_pkg::CH_W];
	assign blue_out  = out_color_q[2*gcl_pkg::CH_W +: gcl_pkg::CH_W];
	assign alpha_out = out_color_q[3*gcl_pkg::CH_W +: gcl_pkg::CH_W];

endmodule

FILE: design/gcl_checker.sv
`include "assert_macros.svh"

module gcl_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     cmd,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [gcl_pkg::CH_W-1:0] red_out,
	input logic [gcl_pkg::CH_W-1:0] green_out,
	input logic [gcl_pkg::CH_W-1:0] blue_out,
	input logic [gcl_pkg::CH_W-1:0] alpha_out
);

	logic [gcl_pkg::COLOR_W-1:0] out_rgba;

	assign out_rgba = {alpha_out, blue_out, green_out, red_out};

	`GCL_ASSERT_NEXT(a_lookup_busy, in_valid && !in_stall && (cmd == gcl_pkg::CMD_LOOKUP), in_stall)
	`GCL_ASSERT_NEXT(a_write_one_cycle, in_valid && !in_stall && (cmd == gcl_pkg::CMD_WRITE), !in_stall)
	`GCL_ASSERT_NOW(a_result_after_busy, $rose(out_valid), $past(in_stall))
	`GCL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_rgba))

endmodule

bind gradient_colormap_lookup_core gcl_checker u_gcl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.cmd      (cmd),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.red_out  (red_out),
	.green_out(green_out),
	.blue_out (blue_out),
	.alpha_out(alpha_out)
);

FILE: verif/gcl_lookup_checker.sv
module gcl_lookup_checker
	import gcl_pkg::*;
#(
	parameter logic [PADDR_W-1:0] COUNT_ADDR = '0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                cmd,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [POS_W-1:0]    stop_position,
	input  logic [CH_W-1:0]     red_in,
	input  logic [CH_W-1:0]     green_in,
	input  logic [CH_W-1:0]     blue_in,
	input  logic [CH_W-1:0]     alpha_in,
	input  logic [KEY_W-1:0]    key,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [CH_W-1:0]     red_out,
	input  logic [CH_W-1:0]     green_out,
	input  logic [CH_W-1:0]     blue_out,
	input  logic [CH_W-1:0]     alpha_out,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	input  logic [PDATA_W-1:0]  prdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CH_W-1:0] alpha;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgba_t;

	logic [POS_W-1:0]   stop_pos  [MAX_STOPS];
	rgba_t              stop_rgba [MAX_STOPS];
	logic [COUNT_W-1:0] count_reg;
	rgba_t              pending_colors [$];
	rgba_t              want;
	int                 fails = 0;

	function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] a, b,
			input logic [POS_W-1:0] seg_len, off);
		logic [31:0] num;
		num = 32'(a) * 32'(seg_len - off) + 32'(b) * 32'(off);
		return CH_W'(num / 32'(seg_len));
	endfunction

	function automatic rgba_t blend_lookup(input logic [KEY_W-1:0] raw_key);
		logic [POS_W-1:0] k, pi, pj, seg_len, off;
		int               n, lo, hi, mid, sel;
		bit               found;
		rgba_t            ci, cj, mixed;
		k = (raw_key == KEY_W'(POS_ONE)) ? POS_ONE : POS_W'(raw_key[FRACTION_BITS-1:0]);
		n = (count_reg == 0) ? 1 : ((count_reg > MAX_STOPS) ? MAX_STOPS : int'(count_reg));
		lo = 0;
		hi = n - 1;
		found = 1'b0;
		sel = 0;
		while (!found && lo <= hi) begin
			mid = (lo + hi) / 2;
			if (stop_pos[mid] < k) begin
				lo = mid + 1;
			end else if (stop_pos[mid] == k) begin
				found = 1'b1;
				sel = mid;
			end else begin
				hi = mid - 1;
			end
		end
		if (!found) sel = (lo > 0) ? lo - 1 : 0;
		pi = stop_pos[sel];
		ci = stop_rgba[sel];
		if (k <= pi || sel == n - 1) return ci;
		pj = stop_pos[sel + 1];
		cj = stop_rgba[sel + 1];
		if (pj <= pi) return ci;
		seg_len = pj - pi;
		off = k - pi;
		if (off > seg_len) off = seg_len;
		mixed.red   = mix_channel(ci.red,   cj.red,   seg_len, off);
		mixed.green = mix_channel(ci.green, cj.green, seg_len, off);
		mixed.blue  = mix_channel(ci.blue,  cj.blue,  seg_len, off);
		mixed.alpha = mix_channel(ci.alpha, cj.alpha, seg_len, off);
		return mixed;
	endfunction

	task automatic check_channel(input string name, input logic [CH_W-1:0] exp_val,
			input logic [CH_W-1:0] got);
		if (got !== exp_val) begin
			fails++;
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_STOPS; s++) begin
				stop_pos[s] = '0;
				stop_rgba[s] = RESET_COLOR;
			end
			count_reg = COUNT_W'(1);
			pending_colors.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pready && paddr == COUNT_ADDR) begin
				if (pwrite) begin
					count_reg = pwdata[COUNT_W-1:0];
				end else if (prdata !== PDATA_W'(count_reg)) begin
					fails++;
					$display("%0t: color_count read expected %0d, got %0d",
						$time, count_reg, prdata);
				end
			end
			if (out_valid && !out_stall) begin
				if (pending_colors.size() == 0) begin
					fails++;
					$display("%0t: color expected none, got %h %h %h %h", $time,
						red_out, green_out, blue_out, alpha_out);
				end else begin
					want = pending_colors.pop_front();
					check_channel("red_out", want.red, red_out);
					check_channel("green_out", want.green, green_out);
					check_channel("blue_out", want.blue, blue_out);
					check_channel("alpha_out", want.alpha, alpha_out);
				end
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_WRITE) begin
					stop_pos[slot] = stop_position;
					stop_rgba[slot] = {alpha_in, blue_in, green_in, red_in};
				end else begin
					pending_colors.push_back(blend_lookup(key));
				end
			end
			pending <= pending_colors.size();
		end
		fail_count <= fails;
	end

endmodule

FILE: verif/gradient_colormap_lookup_core_test.sv
module gradient_colormap_lookup_core_test;
	import gcl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PADDR_W-1:0] COUNT_ADDR = '0;
	localparam int GAP_MAX      = 11;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int ITEM_TARGET  = 1475;

	typedef struct packed {
		logic               cmd;
		logic [SLOT_W-1:0]  slot;
		logic [POS_W-1:0]   pos;
		logic [COLOR_W-1:0] color;
		logic [KEY_W-1:0]   key;
	} request_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                cmd;
	logic [SLOT_W-1:0]   slot;
	logic [POS_W-1:0]    stop_position;
	logic [CH_W-1:0]     red_in;
	logic [CH_W-1:0]     green_in;
	logic [CH_W-1:0]     blue_in;
	logic [CH_W-1:0]     alpha_in;
	logic [KEY_W-1:0]    key;
	logic                out_valid;
	logic                out_stall;
	logic [CH_W-1:0]     red_out;
	logic [CH_W-1:0]     green_out;
	logic [CH_W-1:0]     blue_out;
	logic [CH_W-1:0]     alpha_out;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	int                  fail_count;
	int                  pending;

	bit                  quiet = 1'b0;
	bit                  hold_req = 1'b0;
	int                  n_writes = 0;
	int                  n_lookups = 0;
	int                  n_settings = 0;
	logic [POS_W-1:0]    stop_shadow [MAX_STOPS];

	gradient_colormap_lookup_core i_dut (.*);

	gcl_lookup_checker #(.COUNT_ADDR(COUNT_ADDR)) i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("gradient_colormap_lookup_core_test: FAIL");
		$finish;
	end

	task automatic drive_request(input request_t rq);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= rq.cmd;
		slot          <= rq.slot;
		stop_position <= rq.pos;
		red_in        <= rq.color[0 +: CH_W];
		green_in      <= rq.color[CH_W +: CH_W];
		blue_in       <= rq.color[2*CH_W +: CH_W];
		alpha_in      <= rq.color[3*CH_W +: CH_W];
		key           <= rq.key;
		do @(posedge clk); while (in_stall);
		if (rq.cmd == CMD_WRITE) n_writes++;
		else n_lookups++;
	endtask

	task automatic write_stop(input int s, input logic [POS_W-1:0] p,
			input logic [COLOR_W-1:0] c);
		request_t rq;
		rq.cmd = CMD_WRITE;
		rq.slot = SLOT_W'(s);
		rq.pos = p;
		rq.color = c;
		rq.key = KEY_W'($urandom);
		stop_shadow[s] = p;
		drive_request(rq);
	endtask

	task automatic lookup_key(input logic [KEY_W-1:0] k);
		request_t rq;
		rq.cmd = CMD_LOOKUP;
		rq.slot = SLOT_W'($urandom);
		rq.pos = POS_W'($urandom);
		rq.color = $urandom;
		rq.key = k;
		drive_request(rq);
	endtask

	// drain in-flight work so the register can be touched
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= COUNT_ADDR;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_count(input int v);
		settle();
		apb_access(1'b1, PDATA_W'(v));
		apb_access(1'b0, PDATA_W'($urandom));
		n_settings++;
	endtask

	function automatic logic [COLOR_W-1:0] random_color();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] pick_key(input int active);
		logic [KEY_W-1:0] k;
		k = KEY_W'($urandom);
		case ($urandom_range(0, 7))
			0: k = KEY_W'(POS_ONE);
			1, 2: k[FRACTION_BITS-1:0] =
				stop_shadow[$urandom_range(0, active - 1)][FRACTION_BITS-1:0];
			3: k = '0;
			4: k = '1;
			5: k[KEY_W-1:FRACTION_BITS] = '0;
			default: ;
		endcase
		return k;
	endfunction

	task automatic fill_sorted(input int count);
		int p;
		p = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 4096);
		for (int s = 0; s < count; s++) begin
			write_stop(s, POS_W'(p), random_color());
			if ($urandom_range(0, 7) != 0) p += $urandom_range(1, 2 * 65536 / count);
			if (p > 131071) p = 131071;
		end
	endtask

	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				n = HOLD_CYCLES;
			end else begin
				n = quiet ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int fixed_counts [7] = '{256, 2, 0, 511, 1, 3, 17};
		int phase;
		int count_val;
		int active;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		cmd           <= CMD_WRITE;
		slot          <= '0;
		stop_position <= '0;
		red_in        <= '0;
		green_in      <= '0;
		blue_in       <= '0;
		alpha_in      <= '0;
		key           <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset table: one stop at position 0, black with alpha 1
		lookup_key('0);
		lookup_key(KEY_W'(POS_ONE));
		lookup_key('1);

		set_count(3);
		write_stop(0, '0, '0);
		write_stop(1, POS_W'(32'h8000), '1);
		write_stop(2, POS_ONE, 32'h80FF4010);
		lookup_key(KEY_W'(32'h00000));
		lookup_key(KEY_W'(32'h04000));
		lookup_key(KEY_W'(32'h08000));
		lookup_key(KEY_W'(32'h10000));
		lookup_key(KEY_W'(32'h1FFFF));
		lookup_key(KEY_W'(32'hFFFFF));
		lookup_key(KEY_W'(32'h34000));
		write_stop(255, '1, '1);
		// next stop at the same position
		write_stop(1, '0, 32'h11223344);
		lookup_key(KEY_W'(32'h00100));
		// stop above 1.0
		write_stop(1, '1, 32'hA5C3F00F);
		lookup_key(KEY_W'(32'h0C000));
		// unsorted table
		write_stop(1, POS_W'(32'h4000), 32'h00FF00FF);
		write_stop(2, POS_W'(32'h2000), 32'hFF00FF00);
		lookup_key(KEY_W'(32'h03000));
		lookup_key(KEY_W'(32'h0F000));

		phase = 0;
		while (n_writes + n_lookups < ITEM_TARGET) begin
			if (phase < 7) count_val = fixed_counts[phase];
			else if ($urandom_range(0, 9) == 0) count_val = $urandom_range(25, 511);
			else count_val = $urandom_range(1, 24);
			set_count(count_val);
			active = (count_val == 0) ? 1 : ((count_val > MAX_STOPS) ? MAX_STOPS : count_val);
			quiet = ($urandom_range(0, 3) == 0);
			fill_sorted(active);
			if (phase == 1) hold_req = 1'b1;
			repeat ($urandom_range(20, 40)) begin
				if ($urandom_range(0, 9) == 0)
					write_stop($urandom_range(0, MAX_STOPS - 1), POS_W'($urandom), $urandom);
				else
					lookup_key(pick_key(active));
			end
			phase++;
		end

		settle();
		$display("covered %0d stop writes and %0d lookups over %0d color_count settings",
			n_writes, n_lookups, n_settings);
		$display("with random gaps on both sides and one %0d-cycle output hold", HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("gradient_colormap_lookup_core_test: PASS");
		end else begin
			$display("gradient_colormap_lookup_core_test: FAIL");
		end
		$finish;
	end

endmodule
